// ----- hdl/bsa_pkg.sv -----
// Shared types and constants for the bitmap slot allocator.
// Used by bsa_word_scan and bitmap_slot_allocator_unit; no dependencies.
package bsa_pkg;

    localparam int SLOT_W    = 7;
    localparam int COUNT_W   = 8;
    localparam int STATUS_W  = 2;
    localparam int MAP_DEPTH = 128;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_FULL       = 2'd1,
        STATUS_NOT_IN_USE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_index;
    } scan_t;

endpackage

// ----- hdl/bsa_word_scan.sv -----
// Lowest-clear-bit search over one bitmap word.
// Depends on bsa_pkg for WORD_W, BIT_W and scan_t.
module bsa_word_scan
    import bsa_pkg::*;
(
    input  logic [WORD_W-1:0] used_word,
    output scan_t             scan
);

    always_comb begin
        scan.found     = 1'b0;
        scan.bit_index = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!used_word[b]) begin
                scan.found     = 1'b1;
                scan.bit_index = BIT_W'(b);
            end
        end
    end

endmodule

// ----- hdl/bitmap_slot_allocator_unit.sv -----
// Top level of the first-fit bitmap slot allocator.
// Depends on bsa_pkg and bsa_word_scan.
//
// Input stream: s_tuser is the operation (allocate or free), s_tdata carries
// the slot to release. Each transfer yields exactly one result transfer on the
// m_ side: m_tuser is the status, m_tdata the granted slot and the free count.
// Allocate walks the in-use bitmap one 32-bit word per cycle through a single
// shared lowest-clear-bit finder, starting at word 0 and stopping at the first
// word holding a free slot (words 0 .. ceil(min(SLOTS,128)/32)-1); it then
// passes through the response state to idle, where the next item can be taken.
// Free and allocate-when-full skip the scan and go straight to the response
// state. The result is loaded into the output register on leaving that state.
// s_tready is low while an item is in work. A result waiting on m_tready sits
// in the output register; the next input is still taken and worked on, and
// only the handoff to the output register waits for the receiver.
// Reset (aresetn low, synchronous) marks every slot free, loads the free count
// with the pool size and drops m_tvalid; the block is ready the next cycle.
module bitmap_slot_allocator_unit
    import bsa_pkg::*;
#(
    parameter int SLOTS = 128
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [6:0] slot_index, [7] zero
    input  logic                s_tuser,   // [0] operation

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [6:0] granted_slot, [14:7] slots_free, [15] zero
    output logic [STATUS_W-1:0] m_tuser    // [1:0] status
);

    localparam int POOL_SLOTS = (SLOTS < MAP_DEPTH) ? SLOTS : MAP_DEPTH;
    localparam int NUM_WORDS  = (POOL_SLOTS + WORD_W - 1) / WORD_W;
    localparam int WIDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    state_t               state_reg, state_next;
    logic [WIDX_W-1:0]    word_idx_reg, word_idx_next;
    logic [WORD_W-1:0]    map_reg [NUM_WORDS];
    logic [WORD_W-1:0]    map_next [NUM_WORDS];
    logic [COUNT_W-1:0]   count_reg, count_next;
    status_t              status_reg, status_next;
    logic [SLOT_W-1:0]    grant_reg, grant_next;
    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg, m_status_next;
    logic [SLOT_W-1:0]    m_slot_reg, m_slot_next;
    logic [COUNT_W-1:0]   m_free_reg, m_free_next;

    logic                 s_accept;
    logic                 out_free;
    logic [SLOT_W-1:0]    slot_in;
    logic                 in_range;
    logic [WIDX_W-1:0]    free_word;
    logic [BIT_W-1:0]     free_bit;
    logic [WORD_W-1:0]    pad_mask;
    logic [WORD_W-1:0]    scan_word;
    scan_t                scan;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign slot_in   = s_tdata[SLOT_W-1:0];
    assign in_range  = (COUNT_W'(slot_in) < COUNT_W'(POOL_SLOTS));
    assign free_word = slot_in[BIT_W +: WIDX_W];
    assign free_bit  = slot_in[BIT_W-1:0];

    // Slots past the pool end read as in use.
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            pad_mask[b] = ((int'(word_idx_reg) * WORD_W + b) >= POOL_SLOTS);
        end
    end

    assign scan_word = map_reg[word_idx_reg] | pad_mask;

    bsa_word_scan u_scan (
        .used_word (scan_word),
        .scan      (scan)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (op_t'(s_tuser) == OP_ALLOC && count_reg != '0) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SCAN: begin
                if (scan.found) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        word_idx_next = word_idx_reg;
        map_next      = map_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        grant_next    = grant_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_slot_next   = m_slot_reg;
        m_free_next   = m_free_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    word_idx_next = '0;
                    grant_next    = '0;
                    status_next   = STATUS_OK;
                    if (op_t'(s_tuser) == OP_ALLOC) begin
                        if (count_reg == '0) begin
                            status_next = STATUS_FULL;
                        end
                    end else if (in_range && map_reg[free_word][free_bit]) begin
                        map_next[free_word][free_bit] = 1'b0;
                        if (count_reg < COUNT_W'(POOL_SLOTS)) begin
                            count_next = count_reg + COUNT_W'(1);
                        end
                    end else begin
                        status_next = STATUS_NOT_IN_USE;
                    end
                end
            end
            ST_SCAN: begin
                if (scan.found) begin
                    map_next[word_idx_reg][scan.bit_index] = 1'b1;
                    count_next = count_reg - COUNT_W'(1);
                    grant_next = SLOT_W'({word_idx_reg, scan.bit_index});
                end else begin
                    word_idx_next = word_idx_reg + WIDX_W'(1);
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_slot_next   = grant_reg;
                    m_free_next   = count_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= COUNT_W'(POOL_SLOTS);
            m_valid_reg <= 1'b0;
            for (int w = 0; w < NUM_WORDS; w++) begin
                map_reg[w] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            map_reg     <= map_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_idx_reg <= word_idx_next;
        status_reg   <= status_next;
        grant_reg    <= grant_next;
        m_status_reg <= m_status_next;
        m_slot_reg   <= m_slot_next;
        m_free_reg   <= m_free_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {1'b0, m_free_reg, m_slot_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(POOL_SLOTS))
        else $error("free count above pool size");

    a_scan_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> count_reg != '0)
        else $error("bitmap scan started with no free slot");

    a_scan_in_map: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> int'(word_idx_reg) < NUM_WORDS)
        else $error("bitmap scan ran past last word");

    a_grant_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN && scan.found |=> count_reg == $past(count_reg) - COUNT_W'(1))
        else $error("grant did not take one slot from the count");

    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg == STATUS_FULL |-> m_free_reg == '0 && m_slot_reg == '0)
        else $error("full status with nonzero slot or count");

endmodule

// ----- bench/bitmap_slot_allocator_unit_tb.sv -----
// Self-checking bench for bitmap_slot_allocator_unit: drives allocate and free transfers
// and checks every result against a first-fit bitmap predictor kept in the bench.
// Depends on bsa_pkg and the allocator RTL; needs no other files.
module bitmap_slot_allocator_unit_tb
    import bsa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 128;
    localparam int POOL_SLOTS = (SLOTS < MAP_DEPTH) ? SLOTS : MAP_DEPTH;
    localparam int IDLE_LIMIT = 1000;

    typedef struct {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] free;
    } grant_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [15:0]         m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    logic [MAP_DEPTH-1:0] slot_map;
    logic [COUNT_W-1:0]   free_slots;
    grant_result_t        pending_grants[$];

    int  error_count  = 0;
    int  idle_cycles  = 0;
    int  stall_left   = 0;
    int  hold_request = 0;
    bit  tx_gaps_on   = 1'b0;
    bit  rx_stalls_on = 1'b0;
    int  full_predicted = 0;
    int  n_alloc = 0, n_free = 0, n_full = 0, n_not_in_use = 0;

    bitmap_slot_allocator_unit #(.SLOTS(SLOTS)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic grant_result_t predict_grant(op_t op, logic [SLOT_W-1:0] slot);
        grant_result_t r;
        bit            hit;
        r.status = STATUS_OK;
        r.slot   = '0;
        hit      = 1'b0;
        if (op == OP_ALLOC) begin
            if (free_slots != 0) begin
                for (int i = 0; i < POOL_SLOTS && !hit; i++) begin
                    if (!slot_map[i]) begin
                        hit         = 1'b1;
                        slot_map[i] = 1'b1;
                        free_slots  = free_slots - 1'b1;
                        r.slot      = i[SLOT_W-1:0];
                    end
                end
            end
            if (!hit) begin
                r.status = STATUS_FULL;
            end
        end else if (slot < POOL_SLOTS && slot_map[slot]) begin
            slot_map[slot] = 1'b0;
            if (free_slots < POOL_SLOTS) begin
                free_slots = free_slots + 1'b1;
            end
        end else begin
            r.status = STATUS_NOT_IN_USE;
        end
        r.free = free_slots;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // send one request; valid stays high across back-to-back transfers
    task automatic send_request(input op_t op, input logic [SLOT_W-1:0] slot);
        int            gap;
        grant_result_t r;
        gap = 0;
        if (tx_gaps_on && $urandom_range(0, 99) < 30) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_grant(op, slot);
        if (r.status == STATUS_FULL) begin
            full_predicted++;
        end else if (op == OP_ALLOC && r.status == STATUS_OK) begin
            n_alloc++;
        end
        pending_grants.push_back(r);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_grants.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [SLOT_W-1:0] pick_in_use_slot();
        int start;
        int idx;
        start = $urandom_range(0, POOL_SLOTS - 1);
        for (int i = 0; i < POOL_SLOTS; i++) begin
            idx = (start + i) % POOL_SLOTS;
            if (slot_map[idx]) begin
                return idx[SLOT_W-1:0];
            end
        end
        return start[SLOT_W-1:0];
    endfunction

    task automatic send_random(input int alloc_pct, input int used_free_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < alloc_pct) begin
            send_request(OP_ALLOC, SLOT_W'($urandom_range(0, 127)));
        end else if (r < alloc_pct + used_free_pct && free_slots < POOL_SLOTS) begin
            send_request(OP_FREE, pick_in_use_slot());
        end else begin
            send_request(OP_FREE, SLOT_W'($urandom_range(0, 127)));
        end
    endtask

    task automatic test_directed();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        send_request(OP_FREE,  7'd0);
        send_request(OP_FREE,  7'd127);
        send_request(OP_ALLOC, 7'd0);
        send_request(OP_ALLOC, 7'd127);
        send_request(OP_ALLOC, 7'h55);
        send_request(OP_FREE,  7'd1);
        send_request(OP_FREE,  7'd1);
        send_request(OP_ALLOC, 7'h2A);
        send_request(OP_FREE,  7'd0);
        send_request(OP_ALLOC, 7'd0);
        send_request(OP_FREE,  7'd64);
        send_request(OP_FREE,  7'd2);
        send_request(OP_FREE,  7'd2);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_request(OP_ALLOC, 7'h7F);
        end
        send_request(OP_FREE, 7'd5);
        send_request(OP_FREE, 7'd9);
        send_request(OP_ALLOC, 7'd0);
        wait_drained();
    endtask

    task automatic test_fill_to_full();
        int n;
        n = 0;
        full_predicted = 0;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        while (full_predicted < 4 && n < 300) begin
            send_random(90, 8);
            n++;
        end
        wait_drained();
        while (free_slots != 0) begin
            send_request(OP_ALLOC, 7'd0);
        end
        send_request(OP_ALLOC, 7'd3);
        send_request(OP_FREE,  7'd127);
        send_request(OP_ALLOC, 7'd0);
        send_request(OP_FREE,  7'd0);
        send_request(OP_FREE,  7'd0);
        send_request(OP_ALLOC, 7'd64);
        send_request(OP_ALLOC, 7'd64);
        wait_drained();
    endtask

    task automatic test_back_pressure();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        hold_request = 200;
        repeat (2) @(posedge aclk);
        for (int i = 0; i < 12; i++) begin
            send_random(50, 40);
        end
        wait_drained();
    endtask

    task automatic test_random_mix();
        for (int p = 0; p < 8; p++) begin
            tx_gaps_on   = $urandom_range(0, 2) != 0;
            rx_stalls_on = $urandom_range(0, 2) != 0;
            for (int i = 0; i < 50; i++) begin
                if (p % 2 == 0) begin
                    send_random(15, 75);
                end else begin
                    send_random(75, 20);
                end
            end
            if (p % 3 == 2) begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                      : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        grant_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_grants.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d tdata=%h",
                                          m_tuser, m_tdata));
            end else begin
                exp_r = pending_grants.pop_front();
                case (exp_r.status)
                    STATUS_FULL:       n_full++;
                    STATUS_NOT_IN_USE: n_not_in_use++;
                    default:           ;
                endcase
                if (m_tuser != exp_r.status) begin
                    report_mismatch($sformatf("status got %0d want %0d", m_tuser, exp_r.status));
                end
                if (m_tdata[6:0] != exp_r.slot) begin
                    report_mismatch($sformatf("granted_slot got %0d want %0d",
                                              m_tdata[6:0], exp_r.slot));
                end
                if (m_tdata[14:7] != exp_r.free) begin
                    report_mismatch($sformatf("slots_free got %0d want %0d",
                                              m_tdata[14:7], exp_r.free));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            if (s_tvalid && s_tready && s_tuser == OP_FREE) begin
                n_free++;
            end
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("bitmap_slot_allocator_unit_tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        slot_map   = '0;
        free_slots = COUNT_W'(POOL_SLOTS);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_fill_to_full();
        test_back_pressure();
        test_random_mix();

        repeat (10) @(posedge aclk);
        foreach (pending_grants[i]) begin
            report_mismatch($sformatf("result never arrived, status %0d slot %0d",
                                      pending_grants[i].status, pending_grants[i].slot));
        end
        $display("covered %0d free requests, %0d slot grants, %0d full refusals,",
                 n_free, n_alloc, n_full);
        $display("%0d frees of idle slots, long receiver hold and drain pauses", n_not_in_use);
        if (error_count == 0) begin
            $display("bitmap_slot_allocator_unit_tb: clean");
        end else begin
            $display("bitmap_slot_allocator_unit_tb: errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/bsa_pkg.sv
hdl/bsa_word_scan.sv
hdl/bitmap_slot_allocator_unit.sv
bench/bitmap_slot_allocator_unit_tb.sv
